/* sv/power_law_least_squares_fit_unit_defines.svh */
// assertion macros shared by the checker of the power law fit unit
// no dependencies
`ifndef POWER_LAW_LEAST_SQUARES_FIT_UNIT_DEFINES_SVH
`define POWER_LAW_LEAST_SQUARES_FIT_UNIT_DEFINES_SVH

// implication whose consequent is checked in the cycle after the antecedent
`define PLSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plsf next-cycle check failed");

// implication checked in the same cycle
`define PLSF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("plsf same-cycle check failed");

`endif

/* sv/plsf_pkg.sv */
// types, constants and the log table of the power law fit unit
// no dependencies
package plsf_pkg;

	localparam logic [7:0] MAX_POINTS = 8'd128;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [30:0] ONE_Q30 = 31'h40000000;
	localparam logic [37:0] RED_BIAS = 38'd13396700124;
	localparam logic [35:0] K_GE6 = 36'd6442450944;
	localparam logic [35:0] K_LT12 = 36'd12884901888;
	localparam logic [23:0] A_MAX = 24'hFFFFFF;
	localparam logic signed [5:0] E_INIT = -6'sd18;
	localparam logic [4:0] LAST_TERM = 5'd20;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_DET,
		OP_DIVB_LD,
		OP_DIVK_LD,
		OP_TDIV_LD,
		OP_DIV_STEP,
		OP_B_SAVE,
		OP_K_SAVE,
		OP_RED_INIT,
		OP_RED_STEP,
		OP_EXP_INIT,
		OP_T_MUL,
		OP_T_SAVE,
		OP_EXP_FIN,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] mul_sel;
	} cmd_t;

	typedef struct packed {
		logic sing;
		logic div_done;
		logic afix;
		logic red_done;
		logic last_term;
		logic out_free;
	} stat_t;

	typedef logic [15:0] log_tab_t [256];

	// shift and subtract quotient, used only while building the table
	function automatic longint unsigned udiv64(input longint unsigned n,
			input longint unsigned d);
		longint unsigned q, r;
		int b;
		q = 0;
		r = 0;
		for (b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [15:0] ln_q13(input int unsigned v);
		longint unsigned m, t, t2, p, acc, total;
		int unsigned e;
		int j, k;
		e = 0;
		acc = 0;
		for (j = 1; j < 8; j++)
			if ((v >> j) != 0)
				e = j;
		if (v < 2)
			return 16'd0;
		m = longint'(v) << (30 - e);
		t = udiv64((m - 64'h40000000) << 30, m + 64'h40000000);
		t2 = (t * t) >> 30;
		p = t;
		for (k = 0; k < 20; k++) begin
			acc = acc + udiv64(p, 64'(2 * k + 1));
			p = (p * t2) >> 30;
		end
		total = longint'(e) * 64'd744261118 + 2 * acc;
		return 16'((total + 64'h10000) >> 17);
	endfunction

	function automatic log_tab_t build_log_table();
		log_tab_t tab;
		int i;
		for (i = 0; i < 256; i++)
			tab[i] = ln_q13(i);
		return tab;
	endfunction

	localparam log_tab_t LOG_TABLE = build_log_table();

endpackage

/* sv/plsf_ctrl.sv */
// sequencer of the power law fit unit: accumulation phase and solve steps
// depends on plsf_pkg
module plsf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tlast,
	input  plsf_pkg::stat_t  stat,
	output logic             s_tready,
	output plsf_pkg::cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_ACC,
		ST_FLUSH,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DET,
		ST_SING_CHK,
		ST_DIVB_LD,
		ST_DIVB_RUN,
		ST_B_SAVE,
		ST_DIVK_LD,
		ST_DIVK_RUN,
		ST_K_SAVE,
		ST_K_CHK,
		ST_RED_INIT,
		ST_RED_RUN,
		ST_EXP_INIT,
		ST_T_MUL,
		ST_T_DLD,
		ST_T_RUN,
		ST_T_SAVE,
		ST_EXP_FIN,
		ST_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] mul_q;

	assign s_tready = (state_q == ST_ACC);
	assign cmd.mul_sel = mul_q;

	always_comb begin
		case (state_q)
			ST_MUL_LO:   cmd.op = plsf_pkg::OP_MUL_LO;
			ST_MUL_HI:   cmd.op = plsf_pkg::OP_MUL_HI;
			ST_DET:      cmd.op = plsf_pkg::OP_DET;
			ST_DIVB_LD:  cmd.op = plsf_pkg::OP_DIVB_LD;
			ST_DIVK_LD:  cmd.op = plsf_pkg::OP_DIVK_LD;
			ST_T_DLD:    cmd.op = plsf_pkg::OP_TDIV_LD;
			ST_DIVB_RUN, ST_DIVK_RUN, ST_T_RUN:
				cmd.op = stat.div_done ? plsf_pkg::OP_NONE : plsf_pkg::OP_DIV_STEP;
			ST_B_SAVE:   cmd.op = plsf_pkg::OP_B_SAVE;
			ST_K_SAVE:   cmd.op = plsf_pkg::OP_K_SAVE;
			ST_RED_INIT: cmd.op = plsf_pkg::OP_RED_INIT;
			ST_RED_RUN:
				cmd.op = stat.red_done ? plsf_pkg::OP_NONE : plsf_pkg::OP_RED_STEP;
			ST_EXP_INIT: cmd.op = plsf_pkg::OP_EXP_INIT;
			ST_T_MUL:    cmd.op = plsf_pkg::OP_T_MUL;
			ST_T_SAVE:   cmd.op = plsf_pkg::OP_T_SAVE;
			ST_EXP_FIN:  cmd.op = plsf_pkg::OP_EXP_FIN;
			ST_OUT:      cmd.op = stat.out_free ? plsf_pkg::OP_OUT : plsf_pkg::OP_NONE;
			default:     cmd.op = plsf_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			mul_q <= 3'd0;
		end else begin
			case (state_q)
				ST_ACC: begin
					if (s_tvalid && s_tlast)
						state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					mul_q <= 3'd0;
					state_q <= ST_MUL_LO;
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: begin
					if (mul_q == 3'd5) begin
						state_q <= ST_DET;
					end else begin
						mul_q <= mul_q + 3'd1;
						state_q <= ST_MUL_LO;
					end
				end
				ST_DET:      state_q <= ST_SING_CHK;
				ST_SING_CHK: state_q <= stat.sing ? ST_OUT : ST_DIVB_LD;
				ST_DIVB_LD:  state_q <= ST_DIVB_RUN;
				ST_DIVB_RUN: begin
					if (stat.div_done)
						state_q <= ST_B_SAVE;
				end
				ST_B_SAVE:   state_q <= ST_DIVK_LD;
				ST_DIVK_LD:  state_q <= ST_DIVK_RUN;
				ST_DIVK_RUN: begin
					if (stat.div_done)
						state_q <= ST_K_SAVE;
				end
				ST_K_SAVE:   state_q <= ST_K_CHK;
				ST_K_CHK:    state_q <= stat.afix ? ST_OUT : ST_RED_INIT;
				ST_RED_INIT: state_q <= ST_RED_RUN;
				ST_RED_RUN: begin
					if (stat.red_done)
						state_q <= ST_EXP_INIT;
				end
				ST_EXP_INIT: state_q <= ST_T_MUL;
				ST_T_MUL:    state_q <= ST_T_DLD;
				ST_T_DLD:    state_q <= ST_T_RUN;
				ST_T_RUN: begin
					if (stat.div_done)
						state_q <= ST_T_SAVE;
				end
				ST_T_SAVE:   state_q <= stat.last_term ? ST_EXP_FIN : ST_T_MUL;
				ST_EXP_FIN:  state_q <= ST_OUT;
				ST_OUT: begin
					if (stat.out_free)
						state_q <= ST_ACC;
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

endmodule

/* sv/plsf_dp.sv */
// datapath of the power law fit unit: log lookup, sums, shared multiplier,
// restoring divider, exp series and result register; depends on plsf_pkg
module plsf_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  plsf_pkg::cmd_t   cmd,
	input  logic             in_xfer,
	input  logic [7:0]       x_number,
	input  logic [7:0]       y_count,
	input  logic             m_tready,
	output plsf_pkg::stat_t  stat,
	output logic             m_tvalid,
	output logic [47:0]      m_tdata,
	output logic             m_tuser
);

	logic [7:0]  cnt_q;
	logic        v_s1;
	logic [15:0] lx_s1, ly_s1;
	logic [31:0] lxx_s1, lxy_s1;
	logic [22:0] sx_q, sy_q;
	logic [38:0] sxx_q, sxy_q;

	logic [22:0] ma;
	logic [38:0] mb;
	logic [19:0] mb_part;
	logic [42:0] mprod;
	logic [42:0] mlo_q;
	logic [61:0] p_q [6];

	logic        sing_q, negk_q, negb_q, afix_q, st_q;
	logic [46:0] d_q;
	logic [61:0] magk_q;
	logic [47:0] magb_q;
	logic [63:0] numb;

	logic [79:0] num_q;
	logic [46:0] rem_q, divisor_q;
	logic [6:0]  dcnt_q;
	logic [47:0] rsh;
	logic        ge;

	logic [63:0] qb;
	logic        big, ge6, lt12;
	logic [35:0] qk;
	logic [37:0] k_q, r_q;
	logic signed [5:0] e_q;

	logic [31:0] sum_q;
	logic [30:0] term_q, tm_q;
	logic [4:0]  i_q;
	logic [60:0] tprod;
	logic signed [6:0] s7;
	logic [5:0]  s_amt;
	logic [63:0] ev;

	logic [23:0] a_q;
	logic [20:0] b_q;

	always_comb begin
		case (cmd.mul_sel)
			3'd0: begin ma = 23'(cnt_q); mb = sxx_q; end
			3'd1: begin ma = sx_q; mb = 39'(sx_q); end
			3'd2: begin ma = sy_q; mb = sxx_q; end
			3'd3: begin ma = sx_q; mb = sxy_q; end
			3'd4: begin ma = 23'(cnt_q); mb = sxy_q; end
			default: begin ma = sy_q; mb = 39'(sx_q); end
		endcase
		mb_part = (cmd.op == plsf_pkg::OP_MUL_HI) ? {1'b0, mb[38:20]} : mb[19:0];
		mprod = 43'(ma) * 43'(mb_part);
	end

	assign numb = {magb_q, 16'd0} + 64'(d_q >> 1);
	assign rsh = {rem_q, num_q[79]};
	assign ge = rsh >= {1'b0, divisor_q};
	assign qb = num_q[63:0];
	assign big = |num_q[79:35];
	assign qk = big ? 36'h800000000 : 36'((36'(num_q[34:0]) + 36'd1) >> 1);
	assign ge6 = !negk_q && (qk >= plsf_pkg::K_GE6);
	assign lt12 = negk_q && (qk > plsf_pkg::K_LT12);
	assign tprod = 61'(term_q) * 61'(r_q[29:0]);
	assign s7 = 7'sd14 - 7'(e_q);
	assign s_amt = s7[5:0];
	assign ev = (64'(sum_q) + (64'd1 << (s_amt - 6'd1))) >> s_amt;

	assign stat.sing = sing_q;
	assign stat.div_done = (dcnt_q == 7'd0);
	assign stat.afix = afix_q;
	assign stat.red_done = r_q < 38'(plsf_pkg::LN2_Q30);
	assign stat.last_term = (i_q == plsf_pkg::LAST_TERM);
	assign stat.out_free = !m_tvalid || m_tready;

	// accumulation pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 8'd0;
			v_s1 <= 1'b0;
			sx_q <= '0;
			sy_q <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
		end else if (cmd.op == plsf_pkg::OP_OUT) begin
			cnt_q <= 8'd0;
			v_s1 <= 1'b0;
			sx_q <= '0;
			sy_q <= '0;
			sxx_q <= '0;
			sxy_q <= '0;
		end else begin
			v_s1 <= in_xfer && (cnt_q < plsf_pkg::MAX_POINTS);
			if (in_xfer && (cnt_q < plsf_pkg::MAX_POINTS))
				cnt_q <= cnt_q + 8'd1;
			if (v_s1) begin
				sx_q <= sx_q + 23'(lx_s1);
				sy_q <= sy_q + 23'(ly_s1);
				sxx_q <= sxx_q + 39'(lxx_s1);
				sxy_q <= sxy_q + 39'(lxy_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		lx_s1 <= plsf_pkg::LOG_TABLE[x_number];
		ly_s1 <= plsf_pkg::LOG_TABLE[y_count];
		lxx_s1 <= 32'(plsf_pkg::LOG_TABLE[x_number]) * 32'(plsf_pkg::LOG_TABLE[x_number]);
		lxy_s1 <= 32'(plsf_pkg::LOG_TABLE[x_number]) * 32'(plsf_pkg::LOG_TABLE[y_count]);
	end

	// solve datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= 7'd0;
			sing_q <= 1'b0;
			afix_q <= 1'b0;
			i_q <= 5'd1;
		end else begin
			case (cmd.op)
				plsf_pkg::OP_DET: sing_q <= p_q[0] <= p_q[1];
				plsf_pkg::OP_DIVB_LD, plsf_pkg::OP_DIVK_LD: dcnt_q <=
					(cmd.op == plsf_pkg::OP_DIVB_LD) ? 7'd64 : 7'd80;
				plsf_pkg::OP_TDIV_LD: dcnt_q <= 7'd31;
				plsf_pkg::OP_DIV_STEP: dcnt_q <= dcnt_q - 7'd1;
				plsf_pkg::OP_K_SAVE: afix_q <= ge6 || lt12;
				plsf_pkg::OP_EXP_INIT: i_q <= 5'd1;
				plsf_pkg::OP_T_SAVE: i_q <= i_q + 5'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			plsf_pkg::OP_MUL_LO: mlo_q <= mprod;
			plsf_pkg::OP_MUL_HI: p_q[cmd.mul_sel] <= 62'(mlo_q) + 62'({mprod, 20'd0});
			plsf_pkg::OP_DET: begin
				d_q <= 47'(p_q[0] - p_q[1]);
				negk_q <= p_q[2] < p_q[3];
				magk_q <= (p_q[2] < p_q[3]) ? p_q[3] - p_q[2] : p_q[2] - p_q[3];
				negb_q <= p_q[4] < p_q[5];
				magb_q <= 48'((p_q[4] < p_q[5]) ? p_q[5] - p_q[4] : p_q[4] - p_q[5]);
				st_q <= p_q[0] <= p_q[1];
				a_q <= 24'd0;
				b_q <= 21'd0;
			end
			plsf_pkg::OP_DIVB_LD: begin
				num_q <= {numb, 16'd0};
				rem_q <= '0;
				divisor_q <= d_q;
			end
			plsf_pkg::OP_DIVK_LD: begin
				num_q <= {magk_q, 18'd0};
				rem_q <= '0;
				divisor_q <= d_q;
			end
			plsf_pkg::OP_TDIV_LD: begin
				num_q <= {tm_q, 49'd0};
				rem_q <= '0;
				divisor_q <= 47'(i_q);
			end
			plsf_pkg::OP_DIV_STEP: begin
				rem_q <= ge ? 47'(rsh - {1'b0, divisor_q}) : rsh[46:0];
				num_q <= {num_q[78:0], ge};
			end
			plsf_pkg::OP_B_SAVE: begin
				if (negb_q)
					b_q <= (qb > 64'd1048576) ? 21'h100000 : 21'(64'd0 - qb);
				else
					b_q <= (qb > 64'd1048575) ? 21'h0FFFFF : qb[20:0];
			end
			plsf_pkg::OP_K_SAVE: begin
				k_q <= negk_q ? 38'(38'd0 - 38'(qk)) : 38'(qk);
				if (ge6)
					a_q <= plsf_pkg::A_MAX;
				else
					a_q <= 24'd0;
			end
			plsf_pkg::OP_RED_INIT: begin
				r_q <= k_q + plsf_pkg::RED_BIAS;
				e_q <= plsf_pkg::E_INIT;
			end
			plsf_pkg::OP_RED_STEP: begin
				r_q <= r_q - 38'(plsf_pkg::LN2_Q30);
				e_q <= e_q + 6'sd1;
			end
			plsf_pkg::OP_EXP_INIT: begin
				sum_q <= 32'(plsf_pkg::ONE_Q30);
				term_q <= plsf_pkg::ONE_Q30;
			end
			plsf_pkg::OP_T_MUL: tm_q <= tprod[60:30];
			plsf_pkg::OP_T_SAVE: begin
				term_q <= num_q[30:0];
				sum_q <= sum_q + num_q[31:0];
			end
			plsf_pkg::OP_EXP_FIN: a_q <= (ev > 64'(plsf_pkg::A_MAX)) ? plsf_pkg::A_MAX : ev[23:0];
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.op == plsf_pkg::OP_OUT) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == plsf_pkg::OP_OUT) begin
			m_tdata <= {3'd0, b_q, a_q};
			m_tuser <= st_q;
		end
	end

endmodule

/* sv/power_law_least_squares_fit_unit.sv */
// top level of the power law fit unit y = a * x^b
// depends on plsf_pkg, plsf_ctrl and plsf_dp
//
// Points stream in at one transfer per cycle while s_tready is high; each adds
// ln x, (ln x)^2, ln y and ln x * ln y to exact sums (only the first 128 points
// of a set count). The transfer with tlast closes the set: s_tready then drops
// for the solve (shorter when singular or when a saturates or flushes to zero)
// and any wait on m_tready, set mostly by the one-bit-per-cycle restoring
// divider that computes b, k and the twenty exp series terms. The result waits
// in an output register; a singular set gives zero data with tuser set.
module power_law_least_squares_fit_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // x_number, y_count
	input  logic        s_tlast,   // last_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // coef_a, exponent_b, zero pad
	output logic        m_tuser    // fit_status
);

	plsf_pkg::cmd_t  cmd;
	plsf_pkg::stat_t stat;

	plsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	plsf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_xfer  (s_tvalid && s_tready),
		.x_number (s_tdata[7:0]),
		.y_count  (s_tdata[15:8]),
		.m_tready (m_tready),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* sv/plsf_chk.sv */
// port-level checker for the power law fit unit, bound to the top level
// depends on power_law_least_squares_fit_unit_defines.svh
`include "power_law_least_squares_fit_unit_defines.svh"

module plsf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	`PLSF_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`PLSF_ASSERT_NEXT(a_last_stalls, clk, arst_n, s_tvalid && s_tready && s_tlast, !s_tready)
	`PLSF_ASSERT_SAME(a_sing_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 48'd0)
	`PLSF_ASSERT_SAME(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[47:45] == 3'd0)

endmodule

bind power_law_least_squares_fit_unit plsf_chk u_plsf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
